/* src/chacha20_stream_cipher_top_defines.svh */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top_defines
// Assertion macros shared by the cipher modules.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_TOP_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_TOP_DEFINES_SVH

// Assert that a condition implies a consequence on the next clock
`define CC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the same clock
`define CC_ASSERT_NOW(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

/* src/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types and constants for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int QR_PER_BLOCK = 80;

  localparam logic [2:0] REG_KEY_LO    = 3'd0;
  localparam logic [2:0] REG_KEY_MIDLO = 3'd1;
  localparam logic [2:0] REG_KEY_MIDHI = 3'd2;
  localparam logic [2:0] REG_KEY_HI    = 3'd3;
  localparam logic [2:0] REG_NONCE_LO  = 3'd4;
  localparam logic [2:0] REG_NONCE_HI  = 3'd5;
  localparam logic [2:0] REG_START_CTR = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;     // load initial state
    logic qr;       // run one quarter round
    logic [6:0] qr_idx;
    logic finish;   // add input state back in
    logic emit;     // produce output byte
  } cmd_t;

  // Word indexes a,b,c,d for quarter round slot 0..7 of a double round
  function automatic logic [15:0] qr_sel(input logic [2:0] slot);
    logic [15:0] r;
    case (slot)
      3'd0: r = {4'd12, 4'd8, 4'd4, 4'd0};
      3'd1: r = {4'd13, 4'd9, 4'd5, 4'd1};
      3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
      3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
      3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
      3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
      3'd6: r = {4'd13, 4'd8, 4'd7, 4'd2};
      default: r = {4'd14, 4'd9, 4'd4, 4'd3};
    endcase
    return r;
  endfunction

endpackage

/* src/cc20_datapath.sv */
// ----------------------------------------------------------------------------
// cc20_datapath
// State words, quarter-round unit, keystream store and byte output register.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_top_defines.svh"

module cc20_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  cc20_pkg::cmd_t   cmd,
  input  logic [255:0]     key,
  input  logic [95:0]      nonce,
  input  logic [31:0]      counter,
  input  logic [5:0]       pos,
  input  logic [7:0]       data_in,
  input  logic             last_in,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic [31:0] mix_r [16];
  logic [31:0] init_r [16];
  logic [31:0] ks_r [16];
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [15:0] sel;
  logic [3:0]  ia, ib, ic, id;
  logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
  logic [31:0] ks_word;

  assign sel = cc20_pkg::qr_sel(cmd.qr_idx[2:0]);
  assign ia = sel[3:0];
  assign ib = sel[7:4];
  assign ic = sel[11:8];
  assign id = sel[15:12];

  always_comb begin
    a0 = mix_r[ia] + mix_r[ib];
    d0 = mix_r[id] ^ a0;
    d0 = {d0[15:0], d0[31:16]};
    c0 = mix_r[ic] + d0;
    b0 = mix_r[ib] ^ c0;
    b0 = {b0[19:0], b0[31:20]};
    a1 = a0 + b0;
    d1 = d0 ^ a1;
    d1 = {d1[23:0], d1[31:24]};
    c1 = c0 + d1;
    b1 = b0 ^ c1;
    b1 = {b1[24:0], b1[31:25]};
    a2 = a1; b2 = b1; c2 = c1; d2 = d1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_r[0] <= cc20_pkg::SIGMA0;
      init_r[1] <= cc20_pkg::SIGMA1;
      init_r[2] <= cc20_pkg::SIGMA2;
      init_r[3] <= cc20_pkg::SIGMA3;
      mix_r[0]  <= cc20_pkg::SIGMA0;
      mix_r[1]  <= cc20_pkg::SIGMA1;
      mix_r[2]  <= cc20_pkg::SIGMA2;
      mix_r[3]  <= cc20_pkg::SIGMA3;
      for (int i = 0; i < 8; i++) begin
        init_r[4+i] <= key[32*i +: 32];
        mix_r[4+i]  <= key[32*i +: 32];
      end
      init_r[12] <= counter;
      mix_r[12]  <= counter;
      for (int i = 0; i < 3; i++) begin
        init_r[13+i] <= nonce[32*i +: 32];
        mix_r[13+i]  <= nonce[32*i +: 32];
      end
    end else if (cmd.qr) begin
      mix_r[ia] <= a2;
      mix_r[ib] <= b2;
      mix_r[ic] <= c2;
      mix_r[id] <= d2;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) ks_r[i] <= mix_r[i] + init_r[i];
    end
  end

  assign ks_word = ks_r[pos[5:2]];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= data_in ^ ks_word[8*pos[1:0] +: 8];
      out_last_r <= last_in;
    end
  end

  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

  `CC_ASSERT_NOW(a_excl, clk, rst_n, cmd.load, !cmd.qr && !cmd.emit, "load overlaps work")
  `CC_ASSERT_NOW(a_fin, clk, rst_n, cmd.finish, !cmd.qr && !cmd.load, "finish overlaps round")
  `CC_ASSERT_NEXT(a_lastcopy, clk, rst_n, cmd.emit, out_last == $past(last_in), "last not held")

endmodule

/* src/cc20_ctrl.sv */
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: block generation, byte position, counter and handshakes.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_top_defines.svh"

module cc20_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_last,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  logic [31:0]      start_counter,
  output cc20_pkg::cmd_t   cmd,
  output logic [31:0]      counter,
  output logic [5:0]       pos
);

  cc20_pkg::state_t state_r, state_nxt;
  logic [6:0]  qr_r, qr_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] ctr_r, ctr_nxt;
  logic        mstart_r, mstart_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        last_hold_r, last_hold_nxt;
  logic        accept;

  // accept only with a fresh output slot; one item in work at a time
  assign in_tready = (state_r == cc20_pkg::ST_IDLE) && (!ovalid_r || out_tready);
  assign accept = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign counter = mstart_r ? start_counter : ctr_r;
  assign pos = pos_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cc20_pkg::ST_IDLE:  if (accept) state_nxt = (pos_r == '0) ? cc20_pkg::ST_LOAD
                                                             : cc20_pkg::ST_OUT;
      cc20_pkg::ST_LOAD:  state_nxt = cc20_pkg::ST_ROUND;
      cc20_pkg::ST_ROUND: if (qr_r == 7'(cc20_pkg::QR_PER_BLOCK - 1))
                            state_nxt = cc20_pkg::ST_FINAL;
      cc20_pkg::ST_FINAL: state_nxt = cc20_pkg::ST_OUT;
      cc20_pkg::ST_OUT:   state_nxt = cc20_pkg::ST_IDLE;
      default:            state_nxt = cc20_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.qr_idx = qr_r;
    unique case (state_r)
      cc20_pkg::ST_LOAD:  cmd.load = 1'b1;
      cc20_pkg::ST_ROUND: cmd.qr = 1'b1;
      cc20_pkg::ST_FINAL: cmd.finish = 1'b1;
      cc20_pkg::ST_OUT:   cmd.emit = 1'b1;
      default:            ;
    endcase
  end

  always_comb begin
    qr_nxt = (state_r == cc20_pkg::ST_ROUND) ? qr_r + 7'd1 : '0;
    pos_nxt = pos_r;
    ctr_nxt = ctr_r;
    mstart_nxt = mstart_r;
    last_hold_nxt = accept ? in_last : last_hold_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    if (state_r == cc20_pkg::ST_LOAD) begin
      ctr_nxt = counter + 32'd1;
      mstart_nxt = 1'b0;
    end
    if (state_r == cc20_pkg::ST_OUT) begin
      ovalid_nxt = 1'b1;
      if (last_hold_r) begin
        pos_nxt = '0;
        mstart_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cc20_pkg::ST_IDLE;
      qr_r <= '0;
      pos_r <= '0;
      ctr_r <= '0;
      mstart_r <= 1'b1;
      ovalid_r <= 1'b0;
      last_hold_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      qr_r <= qr_nxt;
      pos_r <= pos_nxt;
      ctr_r <= ctr_nxt;
      mstart_r <= mstart_nxt;
      ovalid_r <= ovalid_nxt;
      last_hold_r <= last_hold_nxt;
    end
  end

  `CC_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `CC_ASSERT_NOW(a_qr, clk, rst_n, state_r == cc20_pkg::ST_ROUND,
                 qr_r < 7'(cc20_pkg::QR_PER_BLOCK), "round count overrun")
  `CC_ASSERT_NEXT(a_emit, clk, rst_n, state_r == cc20_pkg::ST_OUT, out_tvalid, "no result")

endmodule

/* src/chacha20_stream_cipher_top.sv */
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 (RFC 8439) byte stream cipher with stream ports.
// ----------------------------------------------------------------------------
// Each input byte is XORed with the keystream; a set tlast ends the message
// and the next one restarts at start_counter. A byte inside a block goes from
// idle to the output state and back before the next accept. The first byte
// of each 64-byte block also waits for the single quarter-round unit running
// 80 quarter rounds one per cycle. Key and nonce are sampled at block start.
module chacha20_stream_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_lo_r, key_midlo_r, key_midhi_r, key_hi_r, nonce_lo_r;
  logic [31:0] nonce_hi_r, start_ctr_r;
  logic [7:0]  data_r;
  logic        last_r;
  cc20_pkg::cmd_t cmd;
  logic [31:0] counter;
  logic [5:0]  pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_midlo_r <= '0; key_midhi_r <= '0; key_hi_r <= '0;
      nonce_lo_r <= '0; nonce_hi_r <= '0; start_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cc20_pkg::REG_KEY_LO:    key_lo_r <= cfg_wdata;
        cc20_pkg::REG_KEY_MIDLO: key_midlo_r <= cfg_wdata;
        cc20_pkg::REG_KEY_MIDHI: key_midhi_r <= cfg_wdata;
        cc20_pkg::REG_KEY_HI:    key_hi_r <= cfg_wdata;
        cc20_pkg::REG_NONCE_LO:  nonce_lo_r <= cfg_wdata;
        cc20_pkg::REG_NONCE_HI:  nonce_hi_r <= cfg_wdata[31:0];
        cc20_pkg::REG_START_CTR: start_ctr_r <= cfg_wdata[31:0];
        default:                 key_lo_r <= key_lo_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  cc20_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_last(in_tlast),
    .out_tvalid, .out_tready, .start_counter(start_ctr_r),
    .cmd, .counter, .pos
  );

  cc20_datapath u_dp (
    .clk, .rst_n, .cmd,
    .key({key_hi_r, key_midhi_r, key_midlo_r, key_lo_r}),
    .nonce({nonce_hi_r, nonce_lo_r}),
    .counter, .pos, .data_in(data_r), .last_in(last_r),
    .out_byte(out_tdata), .out_last(out_tlast)
  );

endmodule
